>>> rtl/va8_pkg.sv
// Shared definitions for the eight-lane vector ALU.
// Holds the opcode map and the command and response beat types.
// No dependencies.
package va8_pkg;

    // Lane count: default and the number of lanes the ports carry
    localparam int VA8_LANES     = 8;
    localparam int VA8_LANES_MAX = 8;
    localparam int VA8_WORD_W    = 32;

    // Opcode map
    localparam logic [6:0] OPC_ADD  = 7'h01;
    localparam logic [6:0] OPC_SUB  = 7'h02;
    localparam logic [6:0] OPC_MUL  = 7'h03;
    localparam logic [6:0] OPC_AND  = 7'h04;
    localparam logic [6:0] OPC_OR   = 7'h05;
    localparam logic [6:0] OPC_XOR  = 7'h06;
    localparam logic [6:0] OPC_SLL  = 7'h07;
    localparam logic [6:0] OPC_SRL  = 7'h08;
    localparam logic [6:0] OPC_SRA  = 7'h09;
    localparam logic [6:0] OPC_ADDI = 7'h11;
    localparam logic [6:0] OPC_ANDI = 7'h12;
    localparam logic [6:0] OPC_ORI  = 7'h13;
    localparam logic [6:0] OPC_XORI = 7'h14;
    localparam logic [6:0] OPC_LD   = 7'h20;
    localparam logic [6:0] OPC_ST   = 7'h21;
    localparam logic [6:0] OPC_LDS  = 7'h22;
    localparam logic [6:0] OPC_STS  = 7'h23;
    localparam logic [6:0] OPC_BEQ  = 7'h30;
    localparam logic [6:0] OPC_BNE  = 7'h31;
    localparam logic [6:0] OPC_BLT  = 7'h32;
    localparam logic [6:0] OPC_BGE  = 7'h33;

    // Command beat: one warp instruction
    typedef struct packed {
        logic [6:0]         op;
        logic signed [11:0] imm;
        logic [7:0]         lane_mask;
        logic [63:0]        rs1_lanes01;
        logic [63:0]        rs1_lanes23;
        logic [63:0]        rs1_lanes45;
        logic [63:0]        rs1_lanes67;
        logic [63:0]        rs2_lanes01;
        logic [63:0]        rs2_lanes23;
        logic [63:0]        rs2_lanes45;
        logic [63:0]        rs2_lanes67;
    } va8_cmd_t;

    // Response beat: lane results and branch flags
    typedef struct packed {
        logic [63:0] result_lanes01;
        logic [63:0] result_lanes23;
        logic [63:0] result_lanes45;
        logic [63:0] result_lanes67;
        logic [7:0]  branch_taken;
    } va8_rsp_t;

endpackage

>>> rtl/vector_alu_8_lane_core.sv
// Top level of the eight-lane vector ALU: decode, lane execute and result pack.
// Depends on va8_pkg for the opcode map and the beat types.
//
// Each command beat is one warp instruction applied by every lane to its own
// rs1/rs2 words (or the shared sign-extended immediate). The block accepts a
// beat in every cycle that cmd_stall is low and returns its response through
// the registered stages: stage one decodes and picks operands, stage two runs
// the lane adders, shifters, comparators and the 32x32 lane multipliers, stage
// three selects, masks and packs. The lane multiplier stage sets the clock
// period. A stall on the response side holds the pipeline in place; a stage
// that is empty still takes a beat, so bubbles are squeezed out under stall.
module vector_alu_8_lane_core #(
    parameter int LANES = va8_pkg::VA8_LANES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  va8_pkg::va8_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output va8_pkg::va8_rsp_t rsp
);
    import va8_pkg::*;

    localparam int W = VA8_WORD_W;
    localparam int BUS_W = VA8_LANES_MAX * W;

    // Result selection codes
    localparam logic [3:0] SEL_ZERO = 4'd0;
    localparam logic [3:0] SEL_ADD  = 4'd1;
    localparam logic [3:0] SEL_SUB  = 4'd2;
    localparam logic [3:0] SEL_MUL  = 4'd3;
    localparam logic [3:0] SEL_AND  = 4'd4;
    localparam logic [3:0] SEL_OR   = 4'd5;
    localparam logic [3:0] SEL_XOR  = 4'd6;
    localparam logic [3:0] SEL_SLL  = 4'd7;
    localparam logic [3:0] SEL_SRL  = 4'd8;
    localparam logic [3:0] SEL_SRA  = 4'd9;

    // Branch flag selection codes
    localparam logic [2:0] FLG_NONE = 3'd0;
    localparam logic [2:0] FLG_EQ   = 3'd1;
    localparam logic [2:0] FLG_NE   = 3'd2;
    localparam logic [2:0] FLG_LT   = 3'd3;
    localparam logic [2:0] FLG_GE   = 3'd4;

    // Pipeline state
    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [3:0]       s1_rsel_reg;
    logic [2:0]       s1_fsel_reg;
    logic [LANES-1:0] s1_mask_reg;
    logic [W-1:0]     s1_a_reg [LANES];
    logic [W-1:0]     s1_b_reg [LANES];

    logic             s2_is_mul_reg;
    logic [LANES-1:0] s2_mask_reg;
    logic [LANES-1:0] s2_flag_reg;
    logic [W-1:0]     s2_alu_reg  [LANES];
    logic [W-1:0]     s2_prod_reg [LANES];

    va8_rsp_t         s3_rsp_reg;

    // Advance enables, back to front
    logic adv1, adv2, adv3;

    assign adv3 = !s3_valid_reg || !rsp_stall;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;

    assign cmd_stall = !adv1;
    assign rsp_valid = s3_valid_reg;
    assign rsp       = s3_rsp_reg;

    // Stage 1: decode opcode, sign-extend immediate, pick second operand
    logic [3:0]       s1_rsel_next;
    logic [2:0]       s1_fsel_next;
    logic             use_imm;
    logic [W-1:0]     immx;
    logic [BUS_W-1:0] rs1_bus, rs2_bus;

    assign immx    = {{(W-12){cmd.imm[11]}}, cmd.imm};
    assign rs1_bus = {cmd.rs1_lanes67, cmd.rs1_lanes45, cmd.rs1_lanes23, cmd.rs1_lanes01};
    assign rs2_bus = {cmd.rs2_lanes67, cmd.rs2_lanes45, cmd.rs2_lanes23, cmd.rs2_lanes01};

    always_comb
    begin
        s1_rsel_next = SEL_ZERO;
        s1_fsel_next = FLG_NONE;
        use_imm      = 1'b0;
        case (cmd.op)
            OPC_ADD:  s1_rsel_next = SEL_ADD;
            OPC_SUB:  s1_rsel_next = SEL_SUB;
            OPC_MUL:  s1_rsel_next = SEL_MUL;
            OPC_AND:  s1_rsel_next = SEL_AND;
            OPC_OR:   s1_rsel_next = SEL_OR;
            OPC_XOR:  s1_rsel_next = SEL_XOR;
            OPC_SLL:  s1_rsel_next = SEL_SLL;
            OPC_SRL:  s1_rsel_next = SEL_SRL;
            OPC_SRA:  s1_rsel_next = SEL_SRA;
            OPC_ADDI, OPC_LD, OPC_ST, OPC_LDS, OPC_STS:
            begin
                s1_rsel_next = SEL_ADD;
                use_imm      = 1'b1;
            end
            OPC_ANDI:
            begin
                s1_rsel_next = SEL_AND;
                use_imm      = 1'b1;
            end
            OPC_ORI:
            begin
                s1_rsel_next = SEL_OR;
                use_imm      = 1'b1;
            end
            OPC_XORI:
            begin
                s1_rsel_next = SEL_XOR;
                use_imm      = 1'b1;
            end
            OPC_BEQ:  s1_fsel_next = FLG_EQ;
            OPC_BNE:  s1_fsel_next = FLG_NE;
            OPC_BLT:  s1_fsel_next = FLG_LT;
            OPC_BGE:  s1_fsel_next = FLG_GE;
            default:  s1_rsel_next = SEL_ZERO;
        endcase
    end

    // Stage 2: lane arithmetic, logic, shifts, compares and multiply
    logic [W-1:0]     s2_alu_next  [LANES];
    logic [W-1:0]     s2_prod_next [LANES];
    logic [LANES-1:0] s2_flag_next;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            logic [4:0] sh;
            sh = s1_b_reg[i][4:0];
            s2_prod_next[i] = s1_a_reg[i] * s1_b_reg[i];
            case (s1_rsel_reg)
                SEL_ADD: s2_alu_next[i] = s1_a_reg[i] + s1_b_reg[i];
                SEL_SUB: s2_alu_next[i] = s1_a_reg[i] - s1_b_reg[i];
                SEL_AND: s2_alu_next[i] = s1_a_reg[i] & s1_b_reg[i];
                SEL_OR:  s2_alu_next[i] = s1_a_reg[i] | s1_b_reg[i];
                SEL_XOR: s2_alu_next[i] = s1_a_reg[i] ^ s1_b_reg[i];
                SEL_SLL: s2_alu_next[i] = s1_a_reg[i] << sh;
                SEL_SRL: s2_alu_next[i] = s1_a_reg[i] >> sh;
                SEL_SRA: s2_alu_next[i] = W'($signed(s1_a_reg[i]) >>> sh);
                default: s2_alu_next[i] = '0;
            endcase
            case (s1_fsel_reg)
                FLG_EQ:  s2_flag_next[i] = (s1_a_reg[i] == s1_b_reg[i]);
                FLG_NE:  s2_flag_next[i] = (s1_a_reg[i] != s1_b_reg[i]);
                FLG_LT:  s2_flag_next[i] = ($signed(s1_a_reg[i]) < $signed(s1_b_reg[i]));
                FLG_GE:  s2_flag_next[i] = !($signed(s1_a_reg[i]) < $signed(s1_b_reg[i]));
                default: s2_flag_next[i] = 1'b0;
            endcase
        end
    end

    // Stage 3: choose multiplier or ALU word, apply lane mask, pack
    va8_rsp_t              s3_rsp_next;
    logic [BUS_W-1:0]      words;
    logic [VA8_LANES_MAX-1:0] flags;

    always_comb
    begin
        words = '0;
        flags = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (s2_mask_reg[i])
            begin
                words[i*W +: W] = s2_is_mul_reg ? s2_prod_reg[i] : s2_alu_reg[i];
                flags[i]        = s2_flag_reg[i];
            end
        end
        s3_rsp_next.result_lanes01 = words[0*2*W +: 2*W];
        s3_rsp_next.result_lanes23 = words[1*2*W +: 2*W];
        s3_rsp_next.result_lanes45 = words[2*2*W +: 2*W];
        s3_rsp_next.result_lanes67 = words[3*2*W +: 2*W];
        s3_rsp_next.branch_taken   = flags;
    end

    // Valid bits: advance with their stage, clear on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload: load on advance of a valid beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (adv1 && cmd_valid)
        begin
            s1_rsel_reg <= s1_rsel_next;
            s1_fsel_reg <= s1_fsel_next;
            s1_mask_reg <= cmd.lane_mask[LANES-1:0];
            for (int i = 0; i < LANES; i++)
            begin
                s1_a_reg[i] <= rs1_bus[i*W +: W];
                s1_b_reg[i] <= use_imm ? immx : rs2_bus[i*W +: W];
            end
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_is_mul_reg <= (s1_rsel_reg == SEL_MUL);
            s2_mask_reg   <= s1_mask_reg;
            s2_flag_reg   <= s2_flag_next;
            for (int i = 0; i < LANES; i++)
            begin
                s2_alu_reg[i]  <= s2_alu_next[i];
                s2_prod_reg[i] <= s2_prod_next[i];
            end
        end
        if (adv3 && s2_valid_reg)
        begin
            s3_rsp_reg <= s3_rsp_next;
        end
    end

`ifndef SYNTHESIS
    // A branch beat carries zero result words
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.branch_taken != '0) |->
            (rsp.result_lanes01 == '0) && (rsp.result_lanes23 == '0) &&
            (rsp.result_lanes45 == '0) && (rsp.result_lanes67 == '0))
        else $error("branch flags set alongside nonzero result words");

    // An empty decode stage never pushes back on the command side
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !cmd_stall)
        else $error("command stalled with decode stage empty");

    // An accepted command beat lands in the decode stage
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> s1_valid_reg)
        else $error("accepted command beat lost at decode stage");

    // A stage holding a beat under stall keeps it
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !adv2 |=> s2_valid_reg)
        else $error("execute stage dropped a stalled beat");
`endif

endmodule

>>> test/testbench.sv
// Self-checking bench for the eight-lane vector ALU core.
// Drives warp instruction beats, predicts each response and checks it field by field.
// Depends on va8_pkg and vector_alu_8_lane_core.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import va8_pkg::*;

    localparam int LANE_COUNT   = VA8_LANES;
    localparam int RANDOM_WARPS = 1400;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 40;

    // Opcode with no lane function: zero result and zero flags
    localparam logic [6:0] OPC_UNUSED_HI  = 7'h7F;

    localparam logic [6:0] LEGAL_OPS [21] = '{
        OPC_ADD, OPC_SUB, OPC_MUL, OPC_AND, OPC_OR, OPC_XOR, OPC_SLL, OPC_SRL,
        OPC_SRA, OPC_ADDI, OPC_ANDI, OPC_ORI, OPC_XORI, OPC_LD, OPC_ST, OPC_LDS,
        OPC_STS, OPC_BEQ, OPC_BNE, OPC_BLT, OPC_BGE
    };

    // One directed row: operands broadcast to every lane, optional typed-in answer
    typedef struct packed {
        logic [6:0]  op;
        logic [11:0] imm;
        logic [7:0]  mask;
        logic [31:0] a;
        logic [31:0] b;
        logic        has_literal;
        logic [31:0] word;
        logic [7:0]  flags;
    } warp_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    va8_cmd_t  cmd;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    va8_rsp_t  rsp;

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        mismatch_count = 0;
    va8_rsp_t  pending_lane_results [$];
    warp_row_t directed_rows [27];

    vector_alu_8_lane_core #(
        .LANES (LANE_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // Compute the lane results and branch flags of one warp instruction
    function automatic va8_rsp_t predict_warp_result(input va8_cmd_t c);
        logic [255:0] a_all;
        logic [255:0] b_all;
        logic [255:0] r_all;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  immx;
        logic [31:0]  r;
        logic [7:0]   flags;
        va8_rsp_t     p;
        a_all = {c.rs1_lanes67, c.rs1_lanes45, c.rs1_lanes23, c.rs1_lanes01};
        b_all = {c.rs2_lanes67, c.rs2_lanes45, c.rs2_lanes23, c.rs2_lanes01};
        immx  = {{20{c.imm[11]}}, c.imm};
        r_all = '0;
        flags = '0;
        for (int i = 0; i < VA8_LANES_MAX; i++)
        begin
            if (i < LANE_COUNT && c.lane_mask[i])
            begin
                a = a_all[32*i +: 32];
                b = b_all[32*i +: 32];
                r = '0;
                case (c.op)
                    OPC_ADD:  r = a + b;
                    OPC_SUB:  r = a - b;
                    OPC_MUL:  r = a * b;
                    OPC_AND:  r = a & b;
                    OPC_OR:   r = a | b;
                    OPC_XOR:  r = a ^ b;
                    OPC_SLL:  r = a << b[4:0];
                    OPC_SRL:  r = a >> b[4:0];
                    OPC_SRA:  r = $signed(a) >>> b[4:0];
                    OPC_ADDI: r = a + immx;
                    OPC_ANDI: r = a & immx;
                    OPC_ORI:  r = a | immx;
                    OPC_XORI: r = a ^ immx;
                    OPC_LD, OPC_ST, OPC_LDS, OPC_STS: r = a + immx;
                    OPC_BEQ:  flags[i] = (a == b);
                    OPC_BNE:  flags[i] = (a != b);
                    OPC_BLT:  flags[i] = ($signed(a) < $signed(b));
                    OPC_BGE:  flags[i] = !($signed(a) < $signed(b));
                    default:  r = '0;
                endcase
                r_all[32*i +: 32] = r;
            end
        end
        {p.result_lanes67, p.result_lanes45, p.result_lanes23, p.result_lanes01} = r_all;
        p.branch_taken = flags;
        return p;
    endfunction

    // Bias operands towards the corners of signed and unsigned compares
    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(0, 63));
            default: return $urandom;
        endcase
    endfunction

    function automatic va8_cmd_t random_warp();
        va8_cmd_t     c;
        logic [255:0] a_all;
        logic [255:0] b_all;
        logic [31:0]  a;
        c = '0;
        c.op = ($urandom_range(0, 4) == 0) ? 7'($urandom) : LEGAL_OPS[$urandom_range(0, 20)];
        case ($urandom_range(0, 5))
            0:       c.imm = 12'h800;
            1:       c.imm = 12'h7FF;
            2:       c.imm = 12'hFFF;
            default: c.imm = 12'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       c.lane_mask = 8'hFF;
            1:       c.lane_mask = 8'h00;
            default: c.lane_mask = 8'($urandom);
        endcase
        // Make equal operands common so both branch outcomes show up per lane
        for (int i = 0; i < VA8_LANES_MAX; i++)
        begin
            a = random_operand();
            a_all[32*i +: 32] = a;
            b_all[32*i +: 32] = ($urandom_range(0, 3) == 0) ? a : random_operand();
        end
        {c.rs1_lanes67, c.rs1_lanes45, c.rs1_lanes23, c.rs1_lanes01} = a_all;
        {c.rs2_lanes67, c.rs2_lanes45, c.rs2_lanes23, c.rs2_lanes01} = b_all;
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one command beat, idling first at random; queue its answer once taken
    task automatic issue_warp(input va8_cmd_t c, input va8_rsp_t want);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !cmd_stall;
            @(posedge clk);
        end
        while (!taken);
        pending_lane_results.push_back(want);
    endtask

    // Stall the response side at random
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Check each response beat that will be taken at the coming edge
    always @(negedge clk)
    begin : response_check
        va8_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_lane_results.size() == 0)
            begin
                report_mismatch("unexpected response beat", rsp.result_lanes01, '0);
            end
            else
            begin
                want = pending_lane_results.pop_front();
                if (rsp.result_lanes01 !== want.result_lanes01)
                    report_mismatch("result_lanes01", rsp.result_lanes01, want.result_lanes01);
                if (rsp.result_lanes23 !== want.result_lanes23)
                    report_mismatch("result_lanes23", rsp.result_lanes23, want.result_lanes23);
                if (rsp.result_lanes45 !== want.result_lanes45)
                    report_mismatch("result_lanes45", rsp.result_lanes45, want.result_lanes45);
                if (rsp.result_lanes67 !== want.result_lanes67)
                    report_mismatch("result_lanes67", rsp.result_lanes67, want.result_lanes67);
                if (rsp.branch_taken !== want.branch_taken)
                    report_mismatch("branch_taken", 64'(rsp.branch_taken),
                                    64'(want.branch_taken));
            end
        end
    end

    // Stimulus: reset, directed table, then random warps over three idling phases
    initial
    begin
        va8_cmd_t     warp;
        va8_rsp_t     want;
        warp_row_t    row;
        logic [255:0] lit;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;

        //                op          imm     mask   a             b
        //                lit   word          flags
        directed_rows = '{
            '{OPC_ADD,  12'h000, 8'hFF, 32'h0000_0000, 32'h0000_0000,
              1'b1, 32'h0000_0000, 8'h00},
            '{OPC_ADD,  12'h000, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0001,
              1'b1, 32'h0000_0000, 8'h00},
            '{OPC_ADD,  12'h000, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1'b1, 32'h0000_0000, 8'h00},
            '{OPC_SUB,  12'h000, 8'hFF, 32'h0000_0000, 32'h0000_0001,
              1'b1, 32'hFFFF_FFFF, 8'h00},
            '{OPC_MUL,  12'h000, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1'b1, 32'h0000_0001, 8'h00},
            '{OPC_MUL,  12'h7FF, 8'hA5, 32'h1234_5678, 32'h9ABC_DEF0,
              1'b0, 32'h0000_0000, 8'h00},
            '{OPC_AND,  12'h000, 8'hFF, 32'hF0F0_F0F0, 32'hFF00_FF00,
              1'b0, 32'h0000_0000, 8'h00},
            '{OPC_OR,   12'h000, 8'h5A, 32'hF0F0_F0F0, 32'h0F0F_0F0F,
              1'b0, 32'h0000_0000, 8'h00},
            '{OPC_XOR,  12'h000, 8'hFF, 32'hAAAA_AAAA, 32'hFFFF_FFFF,
              1'b1, 32'h5555_5555, 8'h00},
            '{OPC_SLL,  12'h000, 8'hFF, 32'h0000_0001, 32'h0000_003F,
              1'b1, 32'h8000_0000, 8'h00},
            '{OPC_SRL,  12'h000, 8'hFF, 32'h8000_0000, 32'hFFFF_FFFF,
              1'b1, 32'h0000_0001, 8'h00},
            '{OPC_SRA,  12'h000, 8'hFF, 32'h8000_0000, 32'h0000_001F,
              1'b1, 32'hFFFF_FFFF, 8'h00},
            '{OPC_SRA,  12'h000, 8'hFF, 32'h8000_0000, 32'h0000_0020,
              1'b1, 32'h8000_0000, 8'h00},
            '{OPC_ADDI, 12'h800, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF,
              1'b1, 32'hFFFF_F800, 8'h00},
            '{OPC_ADDI, 12'h7FF, 8'hFF, 32'h0000_0001, 32'h0000_0000,
              1'b1, 32'h0000_0800, 8'h00},
            '{OPC_ANDI, 12'hFFF, 8'hC3, 32'hDEAD_BEEF, 32'h0000_0000,
              1'b0, 32'h0000_0000, 8'h00},
            '{OPC_ORI,  12'h555, 8'hFF, 32'h1234_0000, 32'h0000_0000,
              1'b0, 32'h0000_0000, 8'h00},
            '{OPC_XORI, 12'hFFF, 8'hFF, 32'h0000_0000, 32'h0000_0000,
              1'b1, 32'hFFFF_FFFF, 8'h00},
            '{OPC_LD,   12'h004, 8'hFF, 32'h0000_1000, 32'h0000_0000,
              1'b1, 32'h0000_1004, 8'h00},
            '{OPC_ST,   12'hFFC, 8'h0F, 32'h0000_1000, 32'h0000_0000,
              1'b0, 32'h0000_0000, 8'h00},
            '{OPC_LDS,  12'h123, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000,
              1'b0, 32'h0000_0000, 8'h00},
            '{OPC_STS,  12'h800, 8'h80, 32'h8000_0000, 32'h0000_0000,
              1'b0, 32'h0000_0000, 8'h00},
            '{OPC_BEQ,  12'h000, 8'hFF, 32'h0000_0005, 32'h0000_0005,
              1'b1, 32'h0000_0000, 8'hFF},
            '{OPC_BNE,  12'h000, 8'h3C, 32'h0000_0005, 32'h0000_0005,
              1'b1, 32'h0000_0000, 8'h00},
            '{OPC_BLT,  12'h000, 8'hFF, 32'h8000_0000, 32'h0000_0000,
              1'b1, 32'h0000_0000, 8'hFF},
            '{OPC_BGE,  12'h000, 8'h0F, 32'h7FFF_FFFF, 32'h8000_0000,
              1'b1, 32'h0000_0000, 8'h0F},
            '{OPC_UNUSED_HI, 12'hFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1'b1, 32'h0000_0000, 8'h00}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles lightly, receiver stalls heavily
        send_idle_pct  = 7;
        recv_stall_pct = 47;

        // Walk the directed table; typed-in answers take precedence over prediction
        for (int n = 0; n < $size(directed_rows); n++)
        begin
            row  = directed_rows[n];
            warp = '0;
            warp.op          = row.op;
            warp.imm         = row.imm;
            warp.lane_mask   = row.mask;
            warp.rs1_lanes01 = {2{row.a}};
            warp.rs1_lanes23 = {2{row.a}};
            warp.rs1_lanes45 = {2{row.a}};
            warp.rs1_lanes67 = {2{row.a}};
            warp.rs2_lanes01 = {2{row.b}};
            warp.rs2_lanes23 = {2{row.b}};
            warp.rs2_lanes45 = {2{row.b}};
            warp.rs2_lanes67 = {2{row.b}};
            if (row.has_literal)
            begin
                for (int l = 0; l < VA8_LANES_MAX; l++)
                    lit[32*l +: 32] = (l < LANE_COUNT && row.mask[l]) ? row.word : 32'h0;
                {want.result_lanes67, want.result_lanes45,
                 want.result_lanes23, want.result_lanes01} = lit;
                want.branch_taken = row.flags;
            end
            else
            begin
                want = predict_warp_result(warp);
            end
            issue_warp(warp, want);
        end

        // Random warps: light/heavy, then heavy/light, then no idling at all
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 47;
                end
                1:
                begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 7;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (RANDOM_WARPS / 3)
            begin
                warp = random_warp();
                issue_warp(warp, predict_warp_result(warp));
            end
        end
        cmd_valid <= 1'b0;

        // Drain outstanding responses, then give the pipeline time to misbehave
        while (pending_lane_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_lane_results.size() == 0)
            $display("vector_alu_8_lane_core verification clean");
        else
            $display("vector_alu_8_lane_core verification failed");
        $finish;
    end

    // Hard limit on the run
    initial
    begin
        #2_000_000;
        $display("vector_alu_8_lane_core verification failed");
        $finish;
    end

endmodule
